@@ rtl/pfbu_pkg.sv @@
// Shared types and constants of the packed field bit unpacker.
package pfbu_pkg;

  // Bits in one input word and the widest field.
  localparam int unsigned WordBits  = 32;
  localparam int unsigned FieldMax  = 64;
  localparam int unsigned WidthBits = 7;
  localparam int unsigned RemBits   = 6;

  // Register indexes of the configuration port.
  localparam logic RegFieldWidth = 1'b0;
  localparam logic RegBigEndian  = 1'b1;

  // Reset values of the registers.
  localparam logic [WidthBits-1:0] FieldWidthReset = 7'd8;
  localparam logic                 BigEndianReset  = 1'b1;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [WidthBits-1:0] width_eff;
    logic                 big_endian;
    logic                 clear;
  } pfbu_cfg_t;

  // State that the shift unit works on.
  typedef struct packed {
    logic [FieldMax-1:0]  partial;
    logic [WidthBits-1:0] collected;
    logic [WordBits-1:0]  word;
    logic [RemBits-1:0]   rem;
  } pfbu_state_t;

  // One step of the shift unit.
  typedef struct packed {
    pfbu_state_t         next;
    logic [FieldMax-1:0] value;
    logic                complete;
    logic                last;
  } pfbu_step_t;

endpackage

@@ rtl/pfbu_cfg.sv @@
// Configuration registers of the packed field bit unpacker behind an APB-style port.
module pfbu_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output pfbu_pkg::pfbu_cfg_t cfg_o
);
  import pfbu_pkg::*;

  logic [WidthBits-1:0] width_q, width_d;
  logic                 be_q, be_d;
  logic                 clear_q, clear_d;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register write decode; a width write also discards the incomplete field.
  always_comb begin
    width_d = width_q;
    be_d    = be_q;
    clear_d = 1'b0;
    if (wr_en) begin
      unique case (paddr[2])
        RegFieldWidth: begin
          width_d = pwdata[WidthBits-1:0];
          clear_d = 1'b1;
        end
        RegBigEndian: be_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= FieldWidthReset;
      be_q    <= BigEndianReset;
      clear_q <= 1'b0;
    end else begin
      width_q <= width_d;
      be_q    <= be_d;
      clear_q <= clear_d;
    end
  end

  // Read back the register values.
  always_comb begin
    unique case (paddr[2])
      RegFieldWidth: prdata = {{(32-WidthBits){1'b0}}, width_q};
      RegBigEndian:  prdata = {31'b0, be_q};
      default:       prdata = 32'b0;
    endcase
  end

  // Clamp the width into the range of 1 to 64 bits.
  always_comb begin
    if (width_q == '0) begin
      cfg_o.width_eff = 7'd1;
    end else if (width_q > 7'd64) begin
      cfg_o.width_eff = 7'd64;
    end else begin
      cfg_o.width_eff = width_q;
    end
  end
  assign cfg_o.big_endian = be_q;
  assign cfg_o.clear      = clear_q;

endmodule

@@ rtl/pfbu_shift_unit.sv @@
// Shared shift unit: moves one chunk of word bits into the field being built.
module pfbu_shift_unit (
  input  pfbu_pkg::pfbu_state_t    state_i,
  input  logic [6:0]               width_i,
  output pfbu_pkg::pfbu_step_t     step_o
);
  import pfbu_pkg::*;

  logic [WidthBits-1:0] need;
  logic [RemBits-1:0]   n;
  logic [RemBits-1:0]   lsh;
  logic [WordBits-1:0]  taken;
  logic [FieldMax-1:0]  merged;
  logic [WidthBits-1:0] coll_sum;
  logic [RemBits-1:0]   rem_next;

  // Chunk size is the smaller of the word bits left and the field bits missing.
  assign need = width_i - state_i.collected;
  always_comb begin
    if ({1'b0, state_i.rem} < need) begin
      n = state_i.rem;
    end else begin
      n = need[RemBits-1:0];
    end
  end

  // Take the top n bits of the word and append them to the partial field.
  assign lsh      = RemBits'(WordBits) - n;
  assign taken    = state_i.word >> lsh;
  assign merged   = (state_i.partial << n) | {32'b0, taken};
  assign coll_sum = state_i.collected + {1'b0, n};
  assign rem_next = state_i.rem - n;

  // A completed field is emitted and the partial field starts over.
  always_comb begin
    step_o.value         = merged;
    step_o.complete      = (coll_sum == width_i);
    step_o.last          = step_o.complete && ({1'b0, rem_next} < width_i);
    step_o.next.word     = state_i.word << n;
    step_o.next.rem      = rem_next;
    if (step_o.complete) begin
      step_o.next.partial   = '0;
      step_o.next.collected = '0;
    end else begin
      step_o.next.partial   = merged;
      step_o.next.collected = coll_sum;
    end
  end

endmodule

@@ rtl/packed_field_bit_unpacker_core.sv @@
// Top level of the packed field bit unpacker: sequencer, state and output register.
//
// Input channel: in_valid_i / in_ready_o carry one 32-bit word of four file
// bytes (first byte in bits 31 to 24). Output channel: out_valid_o /
// out_ready_i carry one field value, right aligned, with last_of_word_o set on
// the final value taken from a word. Configuration goes through the APB-style
// port: field_width at address 0, big_endian_words at address 4.
// Each accepted word is worked off by one shared shift unit; every cycle it
// moves the smaller of the word bits left and the field bits still missing,
// unless a finished value is held back by an occupied output register. A word
// is worked off in one chunk for each field that ends in it and one for bits
// left over at its end, or in a single chunk when a wide field just extends.
// The block takes no new word while one is being worked on; in_ready_o is high
// again the cycle after the last chunk. A stalled receiver holds the output
// register, and the sequencer waits on each step that would emit a value.
// Reset sets field_width to 8, big_endian_words to 1 and clears the partial
// field, the sequencer and the valid flag of the output register.
module packed_field_bit_unpacker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] word_bytes_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] value_o,
  output logic        last_of_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pfbu_pkg::*;

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e              state_q;
  pfbu_state_t         st_q;
  pfbu_cfg_t           cfg;
  pfbu_step_t          step;
  logic                out_valid_q;
  logic [FieldMax-1:0] value_q;
  logic                last_q;
  logic                in_acc;
  logic                out_free;
  logic                advance;
  logic [WordBits-1:0] ordered;

  pfbu_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pfbu_shift_unit u_shift (
    .state_i (st_q),
    .width_i (cfg.width_eff),
    .step_o  (step)
  );

  // Put the file bytes in word order.
  assign ordered = cfg.big_endian ? word_bytes_i :
                   {word_bytes_i[7:0], word_bytes_i[15:8],
                    word_bytes_i[23:16], word_bytes_i[31:24]};

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_q | out_ready_i;
  assign advance    = (state_q == StRun) && (~step.complete || out_free);

  // Sequencer, working state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      st_q         <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg.clear) begin
        st_q.partial   <= '0;
        st_q.collected <= '0;
      end
      unique case (state_q)
        StIdle: begin
          if (in_acc) begin
            st_q.word <= ordered;
            st_q.rem  <= RemBits'(WordBits);
            state_q   <= StRun;
          end
        end
        StRun: begin
          if (advance) begin
            st_q <= step.next;
            if (step.complete) begin
              out_valid_q <= 1'b1;
            end
            if (step.next.rem == '0) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // Payload of the output register.
  always_ff @(posedge clk_i) begin
    if (advance && step.complete) begin
      value_q <= step.value;
      last_q  <= step.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = value_q;
  assign last_of_word_o = last_q;

  // A word being worked on always has bits left.
  a_run_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRun) |-> (st_q.rem != '0))
    else $error("sequencer running with an empty word");

  // The partial field never holds a whole field once a width change has settled.
  a_coll_lt_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cfg.clear |-> (st_q.collected < cfg.width_eff))
    else $error("partial field reached the field width");

  // An accepted word is loaded in full.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == StRun) && (st_q.rem == RemBits'(WordBits)))
    else $error("accepted word not loaded");

  // A value is never lost from a stalled output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(advance && step.complete))
    else $error("output register overwritten while stalled");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the packed field bit unpacker core.
`timescale 1ns / 1ps

module testbench;

  import pfbu_pkg::*;

  // Byte addresses of the two registers on the configuration port.
  localparam logic [2:0] AddrFieldWidth = {RegFieldWidth, 2'b00};
  localparam logic [2:0] AddrBigEndian  = {RegBigEndian, 2'b00};

  // Cycles to let pass after the last expected value before touching the registers.
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 1000000;

  // One expected field value with its end-of-word flag.
  typedef struct packed {
    logic [63:0] value;
    logic        last;
  } field_result_t;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [31:0] word_bytes_i = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [63:0] value_o;
  logic        last_of_word_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predictor state and its copy of the registers.
  logic [63:0]          acc_bits;
  logic [6:0]           acc_count;
  logic [WidthBits-1:0] width_reg;
  logic                 big_endian_reg;

  field_result_t pending_fields[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   gap_max        = 0;
  int unsigned   stall_max      = 0;
  int unsigned   stall_left     = 0;

  packed_field_bit_unpacker_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .word_bytes_i   (word_bytes_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .value_o        (value_o),
    .last_of_word_o (last_of_word_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Check each output transaction and draw the receiver stall that follows it.
  always @(posedge clk_i) begin
    field_result_t exp_field;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_fields.size() == 0) begin
        mismatch_count++;
        $display("ERROR at %0t: unexpected value, expected none, actual %h last %b",
                 $time, value_o, last_of_word_o);
      end else begin
        exp_field = pending_fields.pop_front();
        if (value_o !== exp_field.value) begin
          mismatch_count++;
          $display("ERROR at %0t: value expected %h, actual %h",
                   $time, exp_field.value, value_o);
        end
        if (last_of_word_o !== exp_field.last) begin
          mismatch_count++;
          $display("ERROR at %0t: last_of_word expected %b, actual %b",
                   $time, exp_field.last, last_of_word_o);
        end
      end
      stall_left = $urandom_range(stall_max, 0);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_ready_i <= (stall_left == 0);
  end

  // Put the file bytes in word order and shift them into fields, MSB first.
  function automatic void predict_word(input logic [31:0] raw);
    logic [31:0]   word;
    int unsigned   width;
    field_result_t word_fields[$];
    if (big_endian_reg) begin
      word = raw;
    end else begin
      word = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
    end
    if (width_reg == 0) begin
      width = 1;
    end else if (width_reg > 64) begin
      width = 64;
    end else begin
      width = 32'(width_reg);
    end
    for (int i = 31; i >= 0; i--) begin
      acc_bits  = {acc_bits[62:0], word[i]};
      acc_count = acc_count + 7'd1;
      if (acc_count >= width) begin
        word_fields.push_back('{value: acc_bits, last: 1'b0});
        acc_bits  = '0;
        acc_count = '0;
      end
    end
    if (word_fields.size() > 0) begin
      word_fields[word_fields.size() - 1].last = 1'b1;
    end
    foreach (word_fields[k]) begin
      pending_fields.push_back(word_fields[k]);
    end
  endfunction

  // Send one word; valid stays high across back-to-back transactions.
  task automatic send_word(input logic [31:0] data);
    int unsigned gap;
    gap = $urandom_range(gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    word_bytes_i <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_word(data);
  endtask

  // Drop valid and wait until every expected value has come out.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk_i);
  endtask

  // Bring the block to idle before a register access or the end of the run.
  task automatic settle();
    in_valid_i <= 1'b0;
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Write a register, mirror it in the predictor, then read it back.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    logic [31:0] exp_rd;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == AddrFieldWidth) begin
      width_reg = data[WidthBits-1:0];
      acc_bits  = '0;
      acc_count = '0;
      exp_rd    = {{(32 - WidthBits){1'b0}}, width_reg};
    end else begin
      big_endian_reg = data[0];
      exp_rd         = {31'b0, big_endian_reg};
    end
    // Read the register back through the same port.
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== exp_rd) begin
      mismatch_count++;
      $display("ERROR at %0t: register %0d read expected %h, actual %h",
               $time, addr, exp_rd, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Register writes with random upper bits that the block must ignore.
  task automatic set_width(input logic [WidthBits-1:0] width);
    settle();
    reg_write(AddrFieldWidth, ($urandom() & ~32'h7F) | {25'b0, width});
  endtask

  task automatic set_big_endian(input logic be);
    settle();
    reg_write(AddrBigEndian, ($urandom() & ~32'h1) | {31'b0, be});
  endtask

  // Word patterns: plain random, zeros, ones, a walking bit, sparse and alternating.
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      3:       return $urandom() & $urandom() & $urandom();
      4:       return $urandom_range(0, 1) ? 32'hAAAA_AAAA : 32'h5555_5555;
      default: return $urandom();
    endcase
  endfunction

  // Default configuration straight out of reset, with no idling.
  task automatic test_reset_defaults();
    gap_max   = 0;
    stall_max = 0;
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0123_4567);
    settle();
  endtask

  // Little-endian byte order, then back to big-endian.
  task automatic test_byte_order();
    gap_max   = 17;
    stall_max = 17;
    set_big_endian(1'b0);
    send_word(32'h0123_4567);
    send_word(32'h8000_0001);
    send_word(32'hA5C3_0F81);
    set_big_endian(1'b1);
    send_word(32'h0123_4567);
  endtask

  // Narrowest and widest fields, and widths that fall outside 1 to 64.
  task automatic test_width_extremes();
    set_width(7'd1);
    send_word(32'hA5C3_0F81);
    set_width(7'd64);
    send_word(32'hDEAD_BEEF);
    send_word(32'h8000_0001);
    set_width(7'd0);
    send_word(32'h0000_0001);
    set_width(7'd127);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0000_0000);
    set_width(7'd65);
    send_word(32'h1234_5678);
    send_word(32'h9ABC_DEF0);
  endtask

  // A width write drops the incomplete field carried between words.
  task automatic test_width_change_discards();
    set_width(7'd24);
    send_word(32'h1234_5678);
    set_width(7'd24);
    send_word(32'h9ABC_DEF0);
    send_word(32'h0F0F_0F0F);
    send_word(32'hF0F0_F0F0);
  endtask

  // Random words over a series of settings; each phase picks its own idling.
  task automatic test_random_words();
    logic [WidthBits-1:0] width;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0:       width = 7'd1;
        1:       width = 7'd64;
        2:       width = 7'd32;
        3:       width = 7'd33;
        default: begin
          case ($urandom_range(0, 9))
            0:       width = 7'd0;
            1:       width = 7'($urandom_range(65, 127));
            default: width = 7'($urandom_range(1, 64));
          endcase
        end
      endcase
      set_width(width);
      set_big_endian(1'($urandom_range(0, 1)));
      gap_max   = $urandom_range(0, 1) ? 17 : 0;
      stall_max = $urandom_range(0, 1) ? 17 : 0;
      for (int n = 0; n < 13; n++) begin
        // Hold the sender once per phase until the output side has caught up.
        if (n == 7) begin
          wait_for_results();
        end
        send_word(random_word());
      end
    end
  endtask

  // Reset, then the tests in turn, then the final verdict.
  initial begin
    acc_bits       = '0;
    acc_count      = '0;
    width_reg      = FieldWidthReset;
    big_endian_reg = BigEndianReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_byte_order();
    test_width_extremes();
    test_width_change_discards();
    test_random_words();
    settle();
    if (mismatch_count == 0 && pending_fields.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
